[rtl/core/b64e_pkg.sv]
// shared types, constants and the alphabet lookup for the base64 stream encoder
package b64e_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       end_of_run;
  } out_t;

  // number of trailing pad characters in a group
  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_ONE  = 2'd1,
    PAD_TWO  = 2'd2
  } pad_t;

  typedef struct packed {
    logic [23:0] group;
    pad_t        pads;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] sextet);
    logic [7:0] v;
    logic [7:0] ch;
    v = {2'b00, sextet};
    if (v < 8'd26) begin
      ch = 8'h41 + v;
    end else if (v < 8'd52) begin
      ch = 8'h61 + (v - 8'd26);
    end else if (v < 8'd62) begin
      ch = 8'h30 + (v - 8'd52);
    end else if (v == 8'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

[rtl/core/b64e_front.sv]
// front end: collects bytes into groups, issuing a job per full or final-ended group
module b64e_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  b64e_pkg::in_t  in_data,
  output logic           job_valid,
  output b64e_pkg::job_t job
);

  logic [15:0] pending_r, pending_nxt;
  logic [1:0]  pos_r, pos_nxt;

  always_comb begin
    pending_nxt = pending_r;
    pos_nxt     = pos_r;
    job_valid   = 1'b0;
    job.group   = {pending_r, in_data.data_byte};
    job.pads    = b64e_pkg::PAD_NONE;
    case (pos_r)
      2'd1: begin
        pending_nxt = {pending_r[7:0], in_data.data_byte};
        pos_nxt     = 2'd2;
        job.group   = {pending_r[7:0], in_data.data_byte, 8'h00};
        job.pads    = b64e_pkg::PAD_ONE;
        job_valid   = in_data.is_final;
      end
      2'd2: begin
        pending_nxt = 16'h0000;
        pos_nxt     = 2'd0;
        job.group   = {pending_r, in_data.data_byte};
        job.pads    = b64e_pkg::PAD_NONE;
        job_valid   = 1'b1;
      end
      default: begin
        pending_nxt = {8'h00, in_data.data_byte};
        pos_nxt     = 2'd1;
        job.group   = {in_data.data_byte, 16'h0000};
        job.pads    = b64e_pkg::PAD_TWO;
        job_valid   = in_data.is_final;
      end
    endcase
    if (in_data.is_final) begin
      pending_nxt = 16'h0000;
      pos_nxt     = 2'd0;
    end
    job_valid = job_valid & accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 16'h0000;
      pos_r     <= 2'd0;
    end else if (accept) begin
      pending_r <= pending_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

[rtl/core/b64e_queue.sv]
// short job queue between the front end and the character sequencer
module b64e_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output b64e_pkg::job_t head
);

  b64e_pkg::job_t mem [b64e_pkg::QueueDepth];

  logic [b64e_pkg::QueuePtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [b64e_pkg::QueuePtrW:0]   count_r;
  logic                           do_push, do_pop;

  assign full    = (count_r == (b64e_pkg::QueuePtrW+1)'(b64e_pkg::QueueDepth));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + (b64e_pkg::QueuePtrW)'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + (b64e_pkg::QueuePtrW)'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (b64e_pkg::QueuePtrW+1)'(1);
        2'b01:   count_r <= count_r - (b64e_pkg::QueuePtrW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/core/b64e_back.sv]
// back end: steps through the four characters of each group job
module b64e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_avail,
  input  b64e_pkg::job_t job_in,
  output logic           job_take,
  output logic           out_empty,
  input  logic           out_pop,
  output b64e_pkg::out_t out_data
);

  b64e_pkg::job_t job_r;
  logic           valid_r, valid_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic [5:0]     sextet;
  logic           is_pad;
  logic           last_char, char_done;

  assign out_empty = ~valid_r;
  assign last_char = (idx_r == 2'd3);
  assign char_done = valid_r & out_pop;
  assign job_take  = job_avail & (~valid_r | (char_done & last_char));

  always_comb begin
    case (idx_r)
      2'd0:    sextet = job_r.group[23:18];
      2'd1:    sextet = job_r.group[17:12];
      2'd2:    sextet = job_r.group[11:6];
      default: sextet = job_r.group[5:0];
    endcase
    is_pad = (last_char && job_r.pads != b64e_pkg::PAD_NONE) ||
             (idx_r == 2'd2 && job_r.pads == b64e_pkg::PAD_TWO);
    out_data.out_char   = is_pad ? b64e_pkg::PadChar : b64e_pkg::b64_char(sextet);
    out_data.end_of_run = last_char;
  end

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (char_done) begin
      idx_nxt = idx_r + 2'd1;
      if (last_char) begin
        valid_nxt = 1'b0;
      end
    end
    if (job_take) begin
      valid_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      job_r <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

[rtl/core/base64_stream_encoder.sv]
// top level of the base64 stream encoder: front end, job queue and character sequencer
// the first character of a group passes through the job queue and the sequencer's job
//   register to reach the result ports after the transaction that completes or ends it
// throughput: one byte per cycle in unless in_full is high, one character per cycle out
//   while out_pop is high; four characters per group in the sequencer set the sustained rate
// reset: synchronous active-low rst_n clears pending bytes, group position and the queue
module base64_stream_encoder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  b64e_pkg::in_t  in_data,
  output logic           out_empty,
  input  logic           out_pop,
  output b64e_pkg::out_t out_data
);

  logic           accept;
  logic           job_valid;
  b64e_pkg::job_t front_job;
  logic           q_empty;
  logic           job_take;
  b64e_pkg::job_t head_job;

  assign accept = in_push & ~in_full;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (front_job)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (front_job),
    .full     (in_full),
    .pop      (job_take),
    .empty    (q_empty),
    .head     (head_job)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (~q_empty),
    .job_in    (head_job),
    .job_take  (job_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
